// ===== rtl/sabi_pkg.sv =====
// ----------------------------------------------------------------------------
// sabi_pkg: shared types and constants for the band integrator
// Register indexes of the configuration port, fixed field widths and the
// saturating accumulate used by both band sums.
// ----------------------------------------------------------------------------
package sabi_pkg;

    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_BAND_LOW      = 3'd0;
    localparam t_cfg_idx CFG_BAND_HIGH     = 3'd1;
    localparam t_cfg_idx CFG_GRID_ORIGIN   = 3'd2;
    localparam t_cfg_idx CFG_GRID_INV_STEP = 3'd3;
    localparam t_cfg_idx CFG_GRID_ENTRIES  = 3'd4;

    localparam int CFG_DATA_W = 32;
    localparam int ENERGY_W   = 32;
    localparam int FLUX_W     = 32;
    localparam int TVAL_W     = 18;
    localparam int TIDX_W     = 12;
    localparam int ENTRIES_W  = 13;
    localparam int SUM_W      = 64;
    localparam int FRAC_W     = 18;

    typedef logic [TVAL_W-1:0] t_tval;
    typedef logic [SUM_W-1:0]  t_sum;

    // Add with saturation at all ones.
    function automatic t_sum sat_add(input t_sum a, input t_sum b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

// ===== rtl/spectrum_absorb_band_integrate.sv =====
// ----------------------------------------------------------------------------
// spectrum_absorb_band_integrate: transmission lookup and band integration
// Applies an interpolated transmission table to each spectrum point and sums
// two band integrals (input and absorbed flux), handed out on the last point.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | beat
//  --------+-----------+----------------------------+-----------------------------
//  in      | sink      | i_in_valid / o_in_ready    | table load or spectrum point
//  out     | source    | o_out_valid / i_out_ready  | absorbed flux, integrals
//  cfg     | sink      | i_cfg_we (no wait)         | register index + data
//
//  A table load is written on the accepting edge. A spectrum point steps
//  through POS, IDX, RD1, ABS, ABSR and DONE when the lookup hits one table
//  entry and no segment is summed; a two-entry interpolation adds T0, T1 and
//  TSUM, and a band segment adds SEG, FM1, FM2 and ADD2. No new beat is taken
//  in the meantime. The steps are set by the one shared 32x32 multiplier
//  (up to 7 products per point) and by the single read port of the table memory.
//  A finished beat waits in the output register; the next input beat is taken
//  meanwhile, and only the final step of a point stalls on a full output.
//  Reset (synchronous, active low) clears control, sums and history, presets
//  config; the table memory is not cleared and holds garbage until loaded.
//
module spectrum_absorb_band_integrate #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_mode,
    input  logic [sabi_pkg::TIDX_W-1:0]     i_table_index,
    input  logic [sabi_pkg::TVAL_W-1:0]     i_table_value,
    input  logic [sabi_pkg::ENERGY_W-1:0]   i_point_energy,
    input  logic [sabi_pkg::FLUX_W-1:0]     i_point_flux,
    input  logic                            i_end_of_spectrum,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [sabi_pkg::FLUX_W-1:0]     o_absorbed_flux,
    output logic [sabi_pkg::SUM_W-1:0]      o_unabsorbed_integral,
    output logic [sabi_pkg::SUM_W-1:0]      o_absorbed_integral,
    output logic                            o_integrals_valid,
    // configuration
    input  logic                            i_cfg_we,
    input  sabi_pkg::t_cfg_idx              i_cfg_index,
    input  logic [sabi_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // table address width and a counter width that can hold the depth
    localparam int IW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = ($clog2(TABLE_DEPTH + 1) > sabi_pkg::ENTRIES_W) ?
                           $clog2(TABLE_DEPTH + 1) : sabi_pkg::ENTRIES_W;
    localparam int PIDX_W = 28;   // integer grid steps in the Q28.36 position

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_POS  = 4'd1;
    localparam logic [3:0] S_IDX  = 4'd2;
    localparam logic [3:0] S_RD1  = 4'd3;
    localparam logic [3:0] S_T0   = 4'd4;
    localparam logic [3:0] S_T1   = 4'd5;
    localparam logic [3:0] S_TSUM = 4'd6;
    localparam logic [3:0] S_ABS  = 4'd7;
    localparam logic [3:0] S_ABSR = 4'd8;
    localparam logic [3:0] S_SEG  = 4'd9;
    localparam logic [3:0] S_FM1  = 4'd10;
    localparam logic [3:0] S_FM2  = 4'd11;
    localparam logic [3:0] S_ADD2 = 4'd12;
    localparam logic [3:0] S_DONE = 4'd13;

    // configuration registers
    logic [31:0]                     r_band_low;
    logic [31:0]                     r_band_high;
    logic [31:0]                     r_grid_origin;
    logic [31:0]                     r_grid_inv_step;
    logic [sabi_pkg::ENTRIES_W-1:0]  r_grid_entries;

    // control and history
    logic [3:0]                      r_state, n_state;
    logic                            r_out_valid;
    logic                            r_have_prev;
    logic [31:0]                     r_prev_energy;
    logic [31:0]                     r_prev_flux;
    logic [31:0]                     r_prev_abs;
    sabi_pkg::t_sum                  r_sum_un;
    sabi_pkg::t_sum                  r_sum_abs;

    // per-point working registers
    logic [31:0]                     r_energy;
    logic [31:0]                     r_flux;
    logic                            r_last;
    logic [31:0]                     r_diff;
    logic                            r_below;
    logic [IW-1:0]                   r_addr;
    logic                            r_single;
    logic [sabi_pkg::FRAC_W-1:0]     r_frac;
    logic [sabi_pkg::FRAC_W:0]       r_frac_c;
    sabi_pkg::t_tval                 r_t0;
    sabi_pkg::t_tval                 r_t1;
    sabi_pkg::t_tval                 r_t;
    logic [63:0]                     r_acc;
    logic [31:0]                     r_abs;
    logic                            r_seg;
    logic [31:0]                     r_de;
    logic [31:0]                     r_em;
    logic [31:0]                     r_fm1;
    logic [31:0]                     r_fm2;
    logic [31:0]                     r_hi;

    // shared multiplier
    logic [31:0]                     mul_a, mul_b;
    logic [63:0]                     r_prod;

    // output register
    logic [31:0]                     r_o_abs;
    sabi_pkg::t_sum                  r_o_sum_un;
    sabi_pkg::t_sum                  r_o_sum_abs;
    logic                            r_o_ivalid;

    // table memory
    sabi_pkg::t_tval                 r_mem [TABLE_DEPTH];
    sabi_pkg::t_tval                 r_rd;
    logic [IW-1:0]                   rd_addr;

    // handshake and decode
    logic                            in_fire;
    logic                            load_fire;
    logic                            point_fire;
    logic                            out_free;
    logic                            tbl_we;

    // lookup decode
    logic [CNT_W-1:0]                ge_ext;
    logic [CNT_W-1:0]                nm1;
    logic                            idx_clamp;
    logic [sabi_pkg::FRAC_W-1:0]     pos_frac;
    logic [IW-1:0]                   lk_addr;
    logic                            lk_single;

    // arithmetic helpers
    logic [63:0]                     tsum;
    logic [63:0]                     abs_rnd;
    logic [31:0]                     abs_sat;
    logic [32:0]                     esum;
    logic [32:0]                     fsum1;
    logic [32:0]                     fsum2;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign load_fire  = in_fire && !i_mode;
    assign point_fire = in_fire && i_mode;
    assign out_free   = !r_out_valid || i_out_ready;
    assign tbl_we     = load_fire && (32'(i_table_index) < 32'(TABLE_DEPTH));

    // ---- lookup decode: clamp the entry count, then pick one or two entries
    assign ge_ext = CNT_W'(r_grid_entries);
    always_comb begin
        if (ge_ext < CNT_W'(2)) begin
            nm1 = CNT_W'(1);
        end else if (32'(ge_ext) > 32'(TABLE_DEPTH)) begin
            nm1 = CNT_W'(TABLE_DEPTH - 1);
        end else begin
            nm1 = ge_ext - CNT_W'(1);
        end
    end

    assign idx_clamp = r_prod[63:36] >= PIDX_W'(nm1);
    assign pos_frac  = r_prod[35:18];

    always_comb begin
        if (r_below) begin
            lk_addr   = '0;
            lk_single = 1'b1;
        end else if (idx_clamp) begin
            lk_addr   = IW'(nm1);
            lk_single = 1'b1;
        end else begin
            lk_addr   = r_prod[36 +: IW];
            // zero fraction needs only the lower entry
            lk_single = (pos_frac == '0);
        end
    end

    // ---- table read address
    always_comb begin
        unique case (r_state)
            S_IDX:   rd_addr = lk_addr;
            S_RD1:   rd_addr = r_addr + IW'(1);
            default: rd_addr = r_addr;
        endcase
    end

    // ---- shared multiplier operand select
    always_comb begin
        unique case (r_state)
            S_POS: begin
                mul_a = r_diff;
                mul_b = r_grid_inv_step;
            end
            S_T0: begin
                mul_a = 32'(r_t0);
                mul_b = 32'(r_frac_c);
            end
            S_T1: begin
                mul_a = 32'(r_t1);
                mul_b = 32'(r_frac);
            end
            S_ABS: begin
                mul_a = r_flux;
                mul_b = 32'(r_t);
            end
            S_SEG: begin
                mul_a = r_de;
                mul_b = r_em;
            end
            S_FM1: begin
                mul_a = r_prod[63:32];
                mul_b = r_fm1;
            end
            S_FM2: begin
                mul_a = r_hi;
                mul_b = r_fm2;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ---- arithmetic around the multiplier
    assign tsum    = r_acc + r_prod + 64'h2_0000;
    assign abs_rnd = r_prod + 64'h1_0000;
    assign abs_sat = (|abs_rnd[63:49]) ? 32'hFFFF_FFFF : abs_rnd[48:17];
    assign esum    = {1'b0, r_prev_energy} + {1'b0, r_energy};
    assign fsum1   = {1'b0, r_prev_flux} + {1'b0, r_flux};
    assign fsum2   = {1'b0, r_prev_abs} + {1'b0, r_abs};

    // ---- sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (point_fire) n_state = S_POS;
            S_POS:  n_state = S_IDX;
            S_IDX:  n_state = S_RD1;
            S_RD1:  n_state = r_single ? S_ABS : S_T0;
            S_T0:   n_state = S_T1;
            S_T1:   n_state = S_TSUM;
            S_TSUM: n_state = S_ABS;
            S_ABS:  n_state = S_ABSR;
            S_ABSR: n_state = r_seg ? S_SEG : S_DONE;
            S_SEG:  n_state = S_FM1;
            S_FM1:  n_state = S_FM2;
            S_FM2:  n_state = S_ADD2;
            S_ADD2: n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ---- control, configuration and history registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_out_valid     <= 1'b0;
            r_have_prev     <= 1'b0;
            r_prev_energy   <= '0;
            r_prev_flux     <= '0;
            r_prev_abs      <= '0;
            r_sum_un        <= '0;
            r_sum_abs       <= '0;
            r_band_low      <= '0;
            r_band_high     <= 32'hFFFF_FFFF;
            r_grid_origin   <= '0;
            r_grid_inv_step <= 32'd65536;
            r_grid_entries  <= 13'd4096;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    sabi_pkg::CFG_BAND_LOW:      r_band_low      <= i_cfg_data;
                    sabi_pkg::CFG_BAND_HIGH:     r_band_high     <= i_cfg_data;
                    sabi_pkg::CFG_GRID_ORIGIN:   r_grid_origin   <= i_cfg_data;
                    sabi_pkg::CFG_GRID_INV_STEP: r_grid_inv_step <= i_cfg_data;
                    sabi_pkg::CFG_GRID_ENTRIES:
                        r_grid_entries <= i_cfg_data[sabi_pkg::ENTRIES_W-1:0];
                    default: ;
                endcase
            end

            // accumulate band segments
            if (r_state == S_FM2) begin
                r_sum_un <= sabi_pkg::sat_add(r_sum_un, r_prod);
            end
            if (r_state == S_ADD2) begin
                r_sum_abs <= sabi_pkg::sat_add(r_sum_abs, r_prod);
            end

            // drop an accepted result beat, then load the finished point
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
                if (r_last) begin
                    r_sum_un      <= '0;
                    r_sum_abs     <= '0;
                    r_have_prev   <= 1'b0;
                    r_prev_energy <= '0;
                    r_prev_flux   <= '0;
                    r_prev_abs    <= '0;
                end else begin
                    r_have_prev   <= 1'b1;
                    r_prev_energy <= r_energy;
                    r_prev_flux   <= r_flux;
                    r_prev_abs    <= r_abs;
                end
            end
        end
    end

    // ---- datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;

        if (point_fire) begin
            r_energy <= i_point_energy;
            r_flux   <= i_point_flux;
            r_last   <= i_end_of_spectrum;
            r_diff   <= i_point_energy - r_grid_origin;
            r_below  <= (i_point_energy <= r_grid_origin);
        end

        unique case (r_state)
            S_POS: begin
                // segment set up from the history while the position multiplies
                r_seg <= r_have_prev && (r_energy > r_band_low) &&
                         (r_energy <= r_band_high) && (r_energy > r_prev_energy);
                r_de  <= r_energy - r_prev_energy;
                r_em  <= esum[32:1];
                r_fm1 <= fsum1[32:1];
            end
            S_IDX: begin
                r_addr   <= lk_addr;
                r_single <= lk_single;
                r_frac   <= pos_frac;
                r_frac_c <= (sabi_pkg::FRAC_W+1)'(1 << sabi_pkg::FRAC_W) -
                            {1'b0, pos_frac};
            end
            S_RD1: begin
                r_t0 <= r_rd;
                r_t  <= r_rd;
            end
            S_T0:   r_t1  <= r_rd;
            S_T1:   r_acc <= r_prod;
            S_TSUM: r_t   <= tsum[35:18];
            S_ABSR: r_abs <= abs_sat;
            S_SEG:  r_fm2 <= fsum2[32:1];
            S_FM1:  r_hi  <= r_prod[63:32];
            default: ;
        endcase

        if (r_state == S_DONE && out_free) begin
            r_o_abs     <= r_abs;
            r_o_sum_un  <= r_last ? r_sum_un  : '0;
            r_o_sum_abs <= r_last ? r_sum_abs : '0;
            r_o_ivalid  <= r_last;
        end
    end

    // ---- table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_mem[IW'(i_table_index)] <= i_table_value;
        end
        r_rd <= r_mem[rd_addr];
    end

    assign o_out_valid           = r_out_valid;
    assign o_absorbed_flux       = r_o_abs;
    assign o_unabsorbed_integral = r_o_sum_un;
    assign o_absorbed_integral   = r_o_sum_abs;
    assign o_integrals_valid     = r_o_ivalid;

`ifndef SYNTH
    // a point holds off the next beat while it is worked on
    a_point_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_mode) |=> !o_in_ready)
        else $error("input taken while a point is in progress");

    // integrals are only nonzero on the closing beat
    a_int_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_integrals_valid) |->
            (o_unabsorbed_integral == '0 && o_absorbed_integral == '0))
        else $error("integrals nonzero on a beat that does not close");

    // lookup address always lands inside the table
    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD1) |-> (32'(r_addr) < 32'(TABLE_DEPTH)))
        else $error("table lookup address beyond depth");

    // a band sum only falls when a spectrum closes
    a_sum_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sum_un < $past(r_sum_un)) |-> $past(r_state == S_DONE && r_last))
        else $error("band sum fell without end of spectrum");
`endif

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: band integrator with transmission lookup
// Fills the transmission table, walks a table of directed beats over the grid
// edges, saturation and band limits, then runs random spectra under several
// register settings and idling patterns. Every result beat is checked field by
// field against a local model of lookup and both band sums, or a typed row.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sabi_pkg::*;

    localparam int          TABLE_DEPTH   = 4096;
    localparam int          SETTLE_CYCLES = 24;    // outlasts the longest point
    localparam int          PHASE_ITEMS   = 117;
    localparam int          NUM_PHASES    = 6;
    localparam int          HOLD_CYCLES   = 300;
    localparam logic        MODE_LOAD     = 1'b0;
    localparam logic        MODE_POINT    = 1'b1;
    localparam logic [31:0] KEV           = 32'h0010_0000;   // 1 keV in Q12.20
    localparam logic [31:0] FLUX_ONE      = 32'h0100_0000;   // 1.0 in Q8.24
    localparam t_tval       TRANS_ONE     = 18'h20000;       // 1.0 in Q1.17

    typedef struct packed {
        logic                mode;
        logic [TIDX_W-1:0]   idx;
        t_tval               val;
        logic [ENERGY_W-1:0] energy;
        logic [FLUX_W-1:0]   flux;
        logic                eos;
    } spec_beat_t;

    typedef struct packed {
        logic [FLUX_W-1:0] absorbed;
        t_sum              unabs;
        t_sum              abs_int;
        logic              iv;
    } band_result_t;

    typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_e;

    typedef struct packed {
        row_kind_e             kind;
        t_cfg_idx              reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        spec_beat_t            beat;
        logic                  typed;   // expected result written in the row
        band_result_t          want;
    } dir_row_t;

    // DUT signals, inputs at known values from time zero
    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic                  in_mode    = MODE_LOAD;
    logic [TIDX_W-1:0]     in_index   = '0;
    t_tval                 in_value   = '0;
    logic [ENERGY_W-1:0]   in_energy  = '0;
    logic [FLUX_W-1:0]     in_flux    = '0;
    logic                  in_eos     = 1'b0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic [FLUX_W-1:0]     out_absorbed;
    t_sum                  out_unabs;
    t_sum                  out_abs_int;
    logic                  out_iv;
    logic                  cfg_we     = 1'b0;
    t_cfg_idx              cfg_index  = CFG_BAND_LOW;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;

    // Model state: table, segment history, sums and register mirror
    t_tval               trans_tbl [TABLE_DEPTH];
    logic [ENERGY_W-1:0] prev_e;
    logic [FLUX_W-1:0]   prev_f;
    logic [FLUX_W-1:0]   prev_af;
    logic                have_prev;
    t_sum                sum_u;
    t_sum                sum_a;
    logic [31:0]         m_band_low;
    logic [31:0]         m_band_high;
    logic [31:0]         m_grid_origin;
    logic [31:0]         m_grid_inv_step;
    logic [12:0]         m_grid_entries;

    band_result_t flux_results_q[$];
    bit           failed       = 1'b0;
    bit           hold_req     = 1'b0;
    int           snd_idle_pct = 0;
    int           rcv_idle_pct = 0;

    spectrum_absorb_band_integrate #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) i_dut (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_in_valid            (in_valid),
        .o_in_ready            (in_ready),
        .i_mode                (in_mode),
        .i_table_index         (in_index),
        .i_table_value         (in_value),
        .i_point_energy        (in_energy),
        .i_point_flux          (in_flux),
        .i_end_of_spectrum     (in_eos),
        .o_out_valid           (out_valid),
        .i_out_ready           (out_ready),
        .o_absorbed_flux       (out_absorbed),
        .o_unabsorbed_integral (out_unabs),
        .o_absorbed_integral   (out_abs_int),
        .o_integrals_valid     (out_iv),
        .i_cfg_we              (cfg_we),
        .i_cfg_index           (cfg_index),
        .i_cfg_data            (cfg_data)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // Interpolated transmission at energy e, clamped at both grid ends.
    function automatic t_tval interp_transmission(input logic [31:0] e);
        logic [63:0] n, p, gi, fr, t0, t1, t;
        n = {51'b0, m_grid_entries};
        if (n < 2) n = 2;
        if (n > TABLE_DEPTH) n = TABLE_DEPTH;
        if (e <= m_grid_origin) return trans_tbl[0];
        p  = {32'b0, e - m_grid_origin} * {32'b0, m_grid_inv_step};
        gi = p >> 36;
        if (gi >= n - 1) return trans_tbl[n - 1];
        fr = {46'b0, p[35:18]};
        t0 = {46'b0, trans_tbl[gi]};
        t1 = {46'b0, trans_tbl[gi + 1]};
        t  = (t0 * (64'h40000 - fr) + t1 * fr + 64'h20000) >> 18;
        return t[TVAL_W-1:0];
    endfunction

    // Trapezoid-like term of one segment; nothing for a flat or falling step.
    function automatic t_sum band_segment(input logic [31:0] e0, input logic [31:0] e1,
                                          input logic [31:0] f0, input logic [31:0] f1);
        logic [63:0] de, em, fm, hi;
        if (e1 <= e0) return '0;
        de = {32'b0, e1} - {32'b0, e0};
        em = ({32'b0, e0} + {32'b0, e1}) >> 1;
        fm = ({32'b0, f0} + {32'b0, f1}) >> 1;
        hi = (de * em) >> 32;
        return hi * fm;
    endfunction

    function automatic t_sum sum_sat(input t_sum a, input t_sum b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

    // Advance the model by one accepted beat; return 1 when it yields a result.
    function automatic bit absorb_and_sum(input spec_beat_t b, output band_result_t r);
        t_tval       t;
        logic [63:0] prod;
        logic [31:0] ab;
        r = '0;
        if (b.mode == MODE_LOAD) begin
            trans_tbl[b.idx] = b.val;
            return 1'b0;
        end
        t    = interp_transmission(b.energy);
        prod = ({32'b0, b.flux} * {46'b0, t} + 64'h10000) >> 17;
        ab   = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
        if (have_prev && b.energy > m_band_low && b.energy <= m_band_high) begin
            sum_u = sum_sat(sum_u, band_segment(prev_e, b.energy, prev_f, b.flux));
            sum_a = sum_sat(sum_a, band_segment(prev_e, b.energy, prev_af, ab));
        end
        r.absorbed = ab;
        if (b.eos) begin
            r.unabs   = sum_u;
            r.abs_int = sum_a;
            r.iv      = 1'b1;
            sum_u     = '0;
            sum_a     = '0;
            have_prev = 1'b0;
            prev_e    = '0;
            prev_f    = '0;
            prev_af   = '0;
        end else begin
            have_prev = 1'b1;
            prev_e    = b.energy;
            prev_f    = b.flux;
            prev_af   = ab;
        end
        return 1'b1;
    endfunction

    function automatic dir_row_t cfg_row(input t_cfg_idx idx, input logic [31:0] val);
        dir_row_t r;
        r         = '0;
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic dir_row_t load_row(input logic [TIDX_W-1:0] idx, input t_tval val);
        dir_row_t r;
        r           = '0;
        r.kind      = ROW_BEAT;
        r.beat.mode = MODE_LOAD;
        r.beat.idx  = idx;
        r.beat.val  = val;
        return r;
    endfunction

    function automatic dir_row_t point_row(input logic [31:0] e, input logic [31:0] f,
                                           input logic eos);
        dir_row_t r;
        r             = '0;
        r.kind        = ROW_BEAT;
        r.beat.mode   = MODE_POINT;
        r.beat.energy = e;
        r.beat.flux   = f;
        r.beat.eos    = eos;
        return r;
    endfunction

    function automatic dir_row_t typed_row(input logic [31:0] e, input logic [31:0] f,
                                           input logic eos, input logic [31:0] ab,
                                           input t_sum u, input t_sum a, input logic iv);
        dir_row_t r;
        r       = point_row(e, f, eos);
        r.typed = 1'b1;
        r.want  = '{ab, u, a, iv};
        return r;
    endfunction

    // Offer one beat, hold it until accepted, then advance the model.
    task automatic send_beat(input spec_beat_t b, input bit typed, input band_result_t want);
        band_result_t r;
        if ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
        end
        in_valid  <= 1'b1;
        in_mode   <= b.mode;
        in_index  <= b.idx;
        in_value  <= b.val;
        in_energy <= b.energy;
        in_flux   <= b.flux;
        in_eos    <= b.eos;
        do @(posedge clk); while (!in_ready);
        if (absorb_and_sum(b, r)) flux_results_q.push_back(typed ? want : r);
    endtask

    // Drop valid, wait for every pending result, then let a load finish.
    task automatic settle_block();
        in_valid <= 1'b0;
        while (flux_results_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_BAND_LOW:      m_band_low      = val;
            CFG_BAND_HIGH:     m_band_high     = val;
            CFG_GRID_ORIGIN:   m_grid_origin   = val;
            CFG_GRID_INV_STEP: m_grid_inv_step = val;
            CFG_GRID_ENTRIES:  m_grid_entries  = val[ENTRIES_W-1:0];
            default: ;
        endcase
    endtask

    // Result sink: check each accepted beat, then pick next ready value.
    // A hold request forces ready low for a long stretch so the block backs up.
    initial begin : result_sink
        band_result_t want;
        band_result_t got;
        int           hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (out_ready && out_valid) begin
                got = '{out_absorbed, out_unabs, out_abs_int, out_iv};
                if (flux_results_q.size() == 0) begin
                    $display("%0t: result beat with nothing pending, got %h", $time, got);
                    failed = 1'b1;
                end else begin
                    want = flux_results_q.pop_front();
                    if (got.absorbed !== want.absorbed) begin
                        $display("%0t: absorbed_flux expected %h, got %h",
                                 $time, want.absorbed, got.absorbed);
                        failed = 1'b1;
                    end
                    if (got.unabs !== want.unabs) begin
                        $display("%0t: unabsorbed_integral expected %h, got %h",
                                 $time, want.unabs, got.unabs);
                        failed = 1'b1;
                    end
                    if (got.abs_int !== want.abs_int) begin
                        $display("%0t: absorbed_integral expected %h, got %h",
                                 $time, want.abs_int, got.abs_int);
                        failed = 1'b1;
                    end
                    if (got.iv !== want.iv) begin
                        $display("%0t: integrals_valid expected %b, got %b",
                                 $time, want.iv, got.iv);
                        failed = 1'b1;
                    end
                end
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    initial begin : stimulus
        dir_row_t     dir_rows[$];
        dir_row_t     row;
        spec_beat_t   b;
        int           sent;
        int           len;
        bit           held;
        logic [31:0]  e_cur, step_max, reach, lo, hi, org, inv;
        logic [12:0]  ents;
        logic [63:0]  span, lim;
        logic [32:0]  e_next;

        // Mirror the reset values of the registers and history.
        m_band_low      = 32'h0;
        m_band_high     = 32'hFFFF_FFFF;
        m_grid_origin   = 32'h0;
        m_grid_inv_step = 32'd65536;
        m_grid_entries  = 13'd4096;
        have_prev       = 1'b0;
        prev_e          = '0;
        prev_f          = '0;
        prev_af         = '0;
        sum_u           = '0;
        sum_a           = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        snd_idle_pct = 25;
        rcv_idle_pct = 62;

        // Fill the whole table first; no point may read an unwritten entry.
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            b      = '0;
            b.mode = MODE_LOAD;
            b.idx  = i[TIDX_W-1:0];
            b.val  = ($urandom_range(3) == 0) ? t_tval'($urandom)
                                              : t_tval'($urandom_range(131072));
            send_beat(b, 1'b0, '0);
        end

        // Directed rows, reset register values until the first register row.
        dir_rows.push_back(load_row(12'd0,    TRANS_ONE));
        dir_rows.push_back(load_row(12'd1,    18'h10000));
        dir_rows.push_back(load_row(12'd4095, 18'h3FFFF));   // above 1.0
        dir_rows.push_back(load_row(12'd4094, 18'h0));
        // below grid, first point of a spectrum: no segment
        dir_rows.push_back(typed_row(32'h0, FLUX_ONE, 1'b1, FLUX_ONE, '0, '0, 1'b1));
        // exactly on grid point 1, half transmission
        dir_rows.push_back(typed_row(KEV, 32'hFFFF_FFFF, 1'b0, 32'h8000_0000, '0, '0, 1'b0));
        dir_rows.push_back(point_row(KEV + KEV / 2, 32'h1234_5678, 1'b0));
        // above grid, last entry above 1.0: absorbed flux saturates
        dir_rows.push_back(typed_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0,
                                     32'hFFFF_FFFF, '0, '0, 1'b0));
        // falling energy closes the spectrum
        dir_rows.push_back(point_row(KEV, FLUX_ONE, 1'b1));
        // equal energies, zero flux
        dir_rows.push_back(point_row(5 * KEV, 32'h0, 1'b0));
        dir_rows.push_back(point_row(5 * KEV, 32'h7FFF_FFFF, 1'b1));
        // empty band
        dir_rows.push_back(cfg_row(CFG_BAND_LOW,  2 * KEV));
        dir_rows.push_back(cfg_row(CFG_BAND_HIGH, KEV));
        dir_rows.push_back(point_row(3 * KEV, FLUX_ONE, 1'b0));
        dir_rows.push_back(point_row(4 * KEV, FLUX_ONE, 1'b1));
        // zero inverse step maps everything to entry 0
        dir_rows.push_back(cfg_row(CFG_GRID_INV_STEP, 32'h0));
        dir_rows.push_back(typed_row(7 * KEV, FLUX_ONE, 1'b1, FLUX_ONE, '0, '0, 1'b1));
        // two-entry grid, offset origin, band edges at 1 and 3 keV
        dir_rows.push_back(cfg_row(CFG_GRID_INV_STEP, 32'd65536));
        dir_rows.push_back(cfg_row(CFG_GRID_ORIGIN,   2 * KEV));
        dir_rows.push_back(cfg_row(CFG_GRID_ENTRIES,  32'd2));
        dir_rows.push_back(cfg_row(CFG_BAND_LOW,      KEV));
        dir_rows.push_back(cfg_row(CFG_BAND_HIGH,     3 * KEV));
        dir_rows.push_back(typed_row(KEV / 2, 32'h0080_0000, 1'b0,
                                     32'h0080_0000, '0, '0, 1'b0));
        dir_rows.push_back(point_row(KEV,      FLUX_ONE,      1'b0));  // on band_low
        dir_rows.push_back(point_row(3 * KEV,  FLUX_ONE,      1'b0));  // on band_high
        dir_rows.push_back(point_row(100 * KEV, 32'h0200_0000, 1'b1));

        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            if (row.kind == ROW_CFG) begin
                settle_block();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                send_beat(row.beat, row.typed, row.want);
            end
        end

        // Random phases: each starts idle with a fresh register set.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    lo = 32'h0; hi = 32'hFFFF_FFFF; org = 32'h0;
                    inv = 32'd65536; ents = 13'd4096;
                end
                1: begin
                    lo   = $urandom_range(32'h0800_0000);
                    hi   = lo + $urandom_range(32'h7000_0000, 32'h0100_0000);
                    org  = $urandom_range(32'h00FF_FFFF);
                    inv  = $urandom_range(32'h0010_0000, 1);
                    ents = 13'd2;
                end
                2: begin
                    lo = 32'h0; hi = 32'hFFFF_FFFF; org = 32'h8000_0000;
                    inv = 32'hFFFF_FFFF; ents = 13'($urandom_range(4096, 2));
                end
                3: begin
                    lo = 32'hFFFF_FFFF; hi = 32'hFFFF_FFFF; org = 32'hFFFF_FFFF;
                    inv = 32'h0004_0000; ents = 13'd4096;
                end
                4: begin
                    lo   = $urandom;
                    hi   = $urandom;
                    org  = $urandom_range(32'h1000_0000);
                    inv  = $urandom_range(32'hFFFF_FFFF, 1);
                    ents = 13'($urandom_range(4096, 2));
                end
                default: begin
                    lo = KEV; hi = 32'h4000_0000; org = 32'h0;
                    inv = 32'd1; ents = 13'd1000;
                end
            endcase

            settle_block();
            write_reg(CFG_BAND_LOW,      lo);
            write_reg(CFG_BAND_HIGH,     hi);
            write_reg(CFG_GRID_ORIGIN,   org);
            write_reg(CFG_GRID_INV_STEP, inv);
            write_reg(CFG_GRID_ENTRIES,  {19'b0, ents});

            // sender 25 / receiver 62, then swapped, then no idling at all
            if (ph < 2) begin
                snd_idle_pct = 25;
                rcv_idle_pct = 62;
            end else if (ph < 4) begin
                snd_idle_pct = 62;
                rcv_idle_pct = 25;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end

            // Energy reach of the loaded grid above the origin.
            span = ({51'b0, m_grid_entries} << 36) /
                   {32'b0, (m_grid_inv_step == 0) ? 32'd1 : m_grid_inv_step};
            lim  = 64'hFFFF_FFFF - {32'b0, m_grid_origin};
            reach = (span > lim) ? lim[31:0] : span[31:0];

            sent = 0;
            held = 1'b0;
            while (sent < PHASE_ITEMS) begin
                if (!held && sent >= 30 && (ph == 1 || ph == 4)) begin
                    hold_req = 1'b1;
                    held     = 1'b1;
                end
                b = '0;
                if ($urandom_range(99) < 8) begin
                    // table rewrite between spectra
                    b.mode = MODE_LOAD;
                    b.idx  = TIDX_W'($urandom);
                    b.val  = ($urandom_range(4) == 0) ? t_tval'($urandom)
                                                      : t_tval'($urandom_range(131072));
                    send_beat(b, 1'b0, '0);
                    sent++;
                end else begin
                    // one spectrum of rising energies, now and then broken
                    len = $urandom_range(12, 1);
                    case ($urandom_range(19))
                        0, 1, 2:    e_cur = $urandom;
                        3, 4, 5, 6: e_cur = $urandom_range(m_grid_origin);
                        default:    e_cur = m_grid_origin + $urandom_range(reach);
                    endcase
                    case ($urandom_range(3))
                        0:       step_max = 32'd16;
                        1:       step_max = (reach >> 4) + 1;
                        2:       step_max = KEV;
                        default: step_max = 32'h1000_0000;
                    endcase
                    for (int j = 0; j < len; j++) begin
                        b.mode = MODE_POINT;
                        if ($urandom_range(99) < 8) begin
                            e_cur = $urandom;
                        end else if (j != 0) begin
                            e_next = {1'b0, e_cur} + {1'b0, $urandom_range(step_max)};
                            e_cur  = e_next[32] ? 32'hFFFF_FFFF : e_next[31:0];
                        end
                        b.energy = e_cur;
                        case ($urandom_range(9))
                            0:          b.flux = 32'h0;
                            1, 2:       b.flux = 32'hFFFF_FFFF - $urandom_range(255);
                            3, 4, 5:    b.flux = $urandom_range(32'h0200_0000);
                            default:    b.flux = $urandom;
                        endcase
                        b.eos = (j == len - 1) && ($urandom_range(19) != 0);
                        send_beat(b, 1'b0, '0);
                        sent++;
                    end
                end
            end
        end

        settle_block();
        if (!failed) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin : watchdog
        #(5_000_000);
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sabi_pkg.sv
rtl/spectrum_absorb_band_integrate.sv
tb/testbench.sv
